// ===== design/pac_pkg.sv =====
// Shared widths, limits, register codes and control types for the PID angle controller.
// No dependencies; every other file of the block refers to this package by scoped names.
package pac_pkg;

    // Field and register widths.
    localparam int ANGLE_W    = 16;
    localparam int PERIOD_W   = 16;
    localparam int GAIN_W     = 32;
    localparam int DRIVE_W    = 17;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
    localparam int                   REG_SETPOINT_IDX = 3;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT   = REG_IDX_W'(REG_SETPOINT_IDX);

    // Internal arithmetic widths.
    localparam int ERR_W       = ANGLE_W + 1;           // setpoint minus angle, exact
    localparam int DIFF_W      = ERR_W + 1;             // change of error, exact
    localparam int MAG_W       = ERR_W;                 // magnitude of that change
    localparam int FRAC_SHIFT  = 16;                    // Q.8 to Q.24 scaling
    localparam int QUOT_W      = 31;                    // unsaturated quotient bits
    localparam int SAT_LSB     = QUOT_W - FRAC_SHIFT;   // magnitude bits above the quotient
    localparam int INTEG_W     = 30;                    // integral state, Q6.24
    localparam int EP_W        = ERR_W + PERIOD_W;      // error times period
    localparam int INTEG_SUM_W = EP_W + 1;
    localparam int PROD_P_W    = ERR_W + GAIN_W;
    localparam int PROD_I_W    = INTEG_W + GAIN_W - 1;
    localparam int D_MCAND_W   = GAIN_W + 1;
    localparam int PROD_D_W    = 2 * GAIN_W;
    localparam int PI_W        = PROD_P_W + 1;
    localparam int SUM_W       = PROD_D_W + 1;
    localparam int CNT_W       = $clog2(GAIN_W);

    // Constants of the control law.
    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(656);

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(9472);
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -ANGLE_MAX;

    localparam logic signed [INTEG_SUM_W-1:0] INTEG_MAX = INTEG_SUM_W'(64'd251658240);
    localparam logic signed [INTEG_SUM_W-1:0] INTEG_MIN = -INTEG_MAX;

    localparam logic signed [SUM_W-1:0] OUT_MAX_Q24 = SUM_W'(64'd4278190080);
    localparam logic signed [SUM_W-1:0] OUT_MIN_Q24 = -OUT_MAX_Q24;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(65280);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -DRIVE_MAX;

    // Control of one serial multiplier: first digit, advance, and the digit itself.
    typedef struct packed {
        logic first;
        logic step;
        logic digit;
    } pac_mul_ctrl_t;

    // Control of the serial divider.
    typedef struct packed {
        logic load;
        logic step;
    } pac_div_ctrl_t;

endpackage

// ===== design/pac_serial_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per stepped cycle, MSB first.
// Depends on pac_pkg for its control struct and default widths.
module pac_serial_mul #(
    parameter int MCAND_W = pac_pkg::ERR_W,
    parameter int ACC_W   = pac_pkg::PROD_P_W
) (
    input  logic                        clk,
    input  pac_pkg::pac_mul_ctrl_t      ctrl,
    input  logic signed [MCAND_W-1:0]   mcand,
    output logic signed [ACC_W-1:0]     product
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] base;

    // Horner form: double the partial product, then add the multiplicand if the digit is set.
    always_comb
    begin
        addend   = ctrl.digit ? ACC_W'(mcand) : '0;
        base     = ctrl.first ? '0 : (acc_reg <<< 1);
        acc_next = ctrl.step ? (base + addend) : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign product = acc_reg;

endmodule

// ===== design/pac_serial_div.sv =====
// Restoring divider, one quotient bit per stepped cycle, most significant bit first.
// Depends on pac_pkg for widths and the divider control struct.
module pac_serial_div (
    input  logic                          clk,
    input  pac_pkg::pac_div_ctrl_t        ctrl,
    input  logic [pac_pkg::MAG_W-1:0]     mag,
    input  logic [pac_pkg::PERIOD_W-1:0]  divisor,
    output logic                          qbit
);

    localparam int FULL_W = pac_pkg::MAG_W + pac_pkg::FRAC_SHIFT;
    localparam int REM_W  = pac_pkg::PERIOD_W;

    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [pac_pkg::QUOT_W-1:0]   dvd_reg, dvd_next;
    logic [REM_W-1:0]             div_reg, div_next;
    logic                         qbit_reg, qbit_next;
    logic [FULL_W-1:0]            full;
    logic [REM_W:0]               trial;
    logic                         ge;

    always_comb
    begin
        full      = {mag, pac_pkg::FRAC_SHIFT'(0)};
        trial     = {rem_reg, dvd_reg[pac_pkg::QUOT_W-1]};
        ge        = trial >= {1'b0, div_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        qbit_next = qbit_reg;
        if (ctrl.load)
        begin
            // The bits above the quotient start as the partial remainder.
            rem_next = REM_W'(full[FULL_W-1:pac_pkg::QUOT_W]);
            dvd_next = full[pac_pkg::QUOT_W-1:0];
            div_next = divisor;
        end
        else if (ctrl.step)
        begin
            rem_next  = ge ? REM_W'(trial - {1'b0, div_reg}) : REM_W'(trial);
            dvd_next  = dvd_reg << 1;
            qbit_next = ge;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        qbit_reg <= qbit_next;
    end

    assign qbit = qbit_reg;

endmodule

// ===== design/pid_angle_controller_top.sv =====
// PID angle controller, top level; uses pac_pkg, pac_serial_mul and pac_serial_div. Each input
// transfer carries a signed Q8.8 measured angle and a Q0.16 sample period (zero selects 656,
// about 1/99.9 s), and produces exactly one output transfer with a signed Q9.8 drive value, a
// safety cutoff flag (angle beyond plus or minus 37 degrees, drive forced to zero) and a clip
// flag (drive limited to plus or minus 255). The integral of error times period is held to
// plus or minus 15 and the derivative is the change of error divided by the period, saturated
// to 32 bits. Gains and setpoint are written over the APB port at byte addresses 0, 4, 8 and
// 12 and read back there; write them only while the block is idle. Items are processed one at
// a time, and the next one is accepted only after the last has passed these steps in order: take
// the transfer, form the error, form the bit-serial product of error and period, update and clamp
// the integral, form the three bit-serial gain products (the divider feeds the derivative product
// one quotient bit per cycle), then sum, limit and register the result. The result waits in an
// output register, so the next item may start while it is still stalled; the block holds in its
// final step only if a second result is ready before the first has been taken.
module pid_angle_controller_top (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pac_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [pac_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [pac_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pac_pkg::ANGLE_W-1:0]     measured_angle,
    input  logic [pac_pkg::PERIOD_W-1:0]           sample_period,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pac_pkg::DRIVE_W-1:0]     drive_value,
    output logic                                   safety_cutoff,
    output logic                                   output_clipped
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_EP    = 3'd2;
    localparam logic [2:0] S_INTEG = 3'd3;
    localparam logic [2:0] S_HORN  = 3'd4;
    localparam logic [2:0] S_FIN0  = 3'd5;
    localparam logic [2:0] S_FIN1  = 3'd6;
    localparam logic [2:0] S_FIN2  = 3'd7;

    localparam int CNT_W = pac_pkg::CNT_W;
    localparam logic [CNT_W-1:0] EP_LAST   = CNT_W'(pac_pkg::PERIOD_W - 1);
    localparam logic [CNT_W-1:0] HORN_LAST = CNT_W'(pac_pkg::GAIN_W - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(pac_pkg::QUOT_W);

    // Control state.
    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Configuration registers.
    logic [pac_pkg::GAIN_W-1:0]          prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [pac_pkg::ANGLE_W-1:0]  setpoint_reg;

    // Controller state carried from item to item.
    logic signed [pac_pkg::ERR_W-1:0]    prev_err_reg, prev_err_next;
    logic signed [pac_pkg::INTEG_W-1:0]  integ_reg, integ_next;

    // Per-item working registers.
    logic signed [pac_pkg::ANGLE_W-1:0]  angle_reg, angle_next;
    logic [pac_pkg::PERIOD_W-1:0]        period_reg, period_next;
    logic [pac_pkg::PERIOD_W-1:0]        per_sh_reg, per_sh_next;
    logic signed [pac_pkg::ERR_W-1:0]    err_reg, err_next;
    logic                                neg_reg, neg_next;
    logic                                sat_reg, sat_next;
    logic [pac_pkg::GAIN_W-1:0]          pg_sh_reg, pg_sh_next;
    logic [pac_pkg::GAIN_W-1:0]          ig_sh_reg, ig_sh_next;
    logic signed [pac_pkg::PI_W-1:0]     pi_reg, pi_next;
    logic signed [pac_pkg::PROD_D_W-1:0] dsig_reg, dsig_next;
    logic signed [pac_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic signed [pac_pkg::DRIVE_W-1:0]  drive_reg, drive_next;
    logic                                cutoff_reg, cutoff_next;
    logic                                clipped_reg, clipped_next;

    // Combinational helpers.
    logic                                 cfg_wr;
    logic [pac_pkg::REG_IDX_W-1:0]        reg_idx;
    logic                                 in_take;
    logic                                 out_load;
    logic signed [pac_pkg::ERR_W-1:0]     err_calc;
    logic signed [pac_pkg::DIFF_W-1:0]    diff;
    logic [pac_pkg::MAG_W-1:0]            absdiff;
    logic signed [pac_pkg::INTEG_SUM_W-1:0] isum;
    logic                                 cutoff_calc;

    // Serial unit control and results.
    pac_pkg::pac_mul_ctrl_t               ep_ctrl, p_ctrl, i_ctrl, d_ctrl;
    pac_pkg::pac_div_ctrl_t               div_ctrl;
    logic signed [pac_pkg::EP_W-1:0]      ep_prod;
    logic signed [pac_pkg::PROD_P_W-1:0]  p_prod;
    logic signed [pac_pkg::PROD_I_W-1:0]  i_prod;
    logic signed [pac_pkg::PROD_D_W-1:0]  d_prod;
    logic signed [pac_pkg::D_MCAND_W-1:0] d_mcand;
    logic                                 qbit;

    // ------------------------------------------------------------------
    // Configuration port: every access completes in its access cycle.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[pac_pkg::APB_ADDR_W-1:2];

    always_comb
    begin
        case (reg_idx)
            pac_pkg::REG_PROP_GAIN:  prdata = prop_gain_reg;
            pac_pkg::REG_INTEG_GAIN: prdata = integ_gain_reg;
            pac_pkg::REG_DERIV_GAIN: prdata = deriv_gain_reg;
            pac_pkg::REG_SETPOINT:   prdata = pac_pkg::APB_DATA_W'(setpoint_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            setpoint_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                pac_pkg::REG_PROP_GAIN:  prop_gain_reg  <= pwdata;
                pac_pkg::REG_INTEG_GAIN: integ_gain_reg <= pwdata;
                pac_pkg::REG_DERIV_GAIN: deriv_gain_reg <= pwdata;
                pac_pkg::REG_SETPOINT:   setpoint_reg   <= pwdata[pac_pkg::ANGLE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Serial arithmetic units.
    // ------------------------------------------------------------------
    assign d_mcand = $signed({1'b0, deriv_gain_reg});

    // Error times period, feeding the integral.
    pac_serial_mul #(
        .MCAND_W (pac_pkg::ERR_W),
        .ACC_W   (pac_pkg::EP_W)
    ) u_mul_ep (
        .clk     (clk),
        .ctrl    (ep_ctrl),
        .mcand   (err_reg),
        .product (ep_prod)
    );

    // Proportional term.
    pac_serial_mul #(
        .MCAND_W (pac_pkg::ERR_W),
        .ACC_W   (pac_pkg::PROD_P_W)
    ) u_mul_p (
        .clk     (clk),
        .ctrl    (p_ctrl),
        .mcand   (err_reg),
        .product (p_prod)
    );

    // Integral term.
    pac_serial_mul #(
        .MCAND_W (pac_pkg::INTEG_W),
        .ACC_W   (pac_pkg::PROD_I_W)
    ) u_mul_i (
        .clk     (clk),
        .ctrl    (i_ctrl),
        .mcand   (integ_reg),
        .product (i_prod)
    );

    // Derivative term: the quotient magnitude streams in as the multiplier.
    pac_serial_mul #(
        .MCAND_W (pac_pkg::D_MCAND_W),
        .ACC_W   (pac_pkg::PROD_D_W)
    ) u_mul_d (
        .clk     (clk),
        .ctrl    (d_ctrl),
        .mcand   (d_mcand),
        .product (d_prod)
    );

    pac_serial_div u_div (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .mag     (absdiff),
        .divisor (period_reg),
        .qbit    (qbit)
    );

    // ------------------------------------------------------------------
    // Sequencer and datapath.
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid & ~in_stall;

    always_comb
    begin
        err_calc    = pac_pkg::ERR_W'(setpoint_reg) - pac_pkg::ERR_W'(angle_reg);
        diff        = pac_pkg::DIFF_W'(err_calc) - pac_pkg::DIFF_W'(prev_err_reg);
        absdiff     = (diff < 0) ? pac_pkg::MAG_W'(-diff) : pac_pkg::MAG_W'(diff);
        isum        = pac_pkg::INTEG_SUM_W'(integ_reg) + pac_pkg::INTEG_SUM_W'(ep_prod);
        cutoff_calc = (angle_reg > pac_pkg::ANGLE_MAX) || (angle_reg < pac_pkg::ANGLE_MIN);
        out_load    = (state_reg == S_FIN2) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        angle_next     = angle_reg;
        period_next    = period_reg;
        per_sh_next    = per_sh_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        pg_sh_next     = pg_sh_reg;
        ig_sh_next     = ig_sh_reg;
        pi_next        = pi_reg;
        dsig_next      = dsig_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        cutoff_next    = cutoff_reg;
        clipped_next   = clipped_reg;

        ep_ctrl  = '0;
        p_ctrl   = '0;
        i_ctrl   = '0;
        d_ctrl   = '0;
        div_ctrl = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    angle_next  = measured_angle;
                    period_next = (sample_period == '0) ? pac_pkg::DEFAULT_PERIOD
                                                        : sample_period;
                    state_next  = S_ERR;
                end
            end

            S_ERR:
            begin
                // Error and its change; the derivative saturates exactly when the
                // quotient would need more than its 31 low bits.
                err_next      = err_calc;
                prev_err_next = err_calc;
                neg_next      = diff < 0;
                sat_next      = pac_pkg::PERIOD_W'(absdiff[pac_pkg::MAG_W-1:pac_pkg::SAT_LSB])
                                >= period_reg;
                div_ctrl.load = 1'b1;
                per_sh_next   = period_reg;
                cnt_next      = '0;
                state_next    = S_EP;
            end

            S_EP:
            begin
                ep_ctrl.first = (cnt_reg == '0);
                ep_ctrl.step  = 1'b1;
                ep_ctrl.digit = per_sh_reg[pac_pkg::PERIOD_W-1];
                per_sh_next   = per_sh_reg << 1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == EP_LAST)
                begin
                    state_next = S_INTEG;
                end
            end

            S_INTEG:
            begin
                // Anti-windup clamp of the integral.
                if (isum > pac_pkg::INTEG_MAX)
                begin
                    integ_next = pac_pkg::INTEG_W'(pac_pkg::INTEG_MAX);
                end
                else if (isum < pac_pkg::INTEG_MIN)
                begin
                    integ_next = pac_pkg::INTEG_W'(pac_pkg::INTEG_MIN);
                end
                else
                begin
                    integ_next = pac_pkg::INTEG_W'(isum);
                end
                pg_sh_next = prop_gain_reg;
                ig_sh_next = integ_gain_reg;
                cnt_next   = '0;
                state_next = S_HORN;
            end

            S_HORN:
            begin
                p_ctrl.first = (cnt_reg == '0);
                p_ctrl.step  = 1'b1;
                p_ctrl.digit = pg_sh_reg[pac_pkg::GAIN_W-1];
                i_ctrl.first = (cnt_reg == '0);
                i_ctrl.step  = 1'b1;
                i_ctrl.digit = ig_sh_reg[pac_pkg::GAIN_W-1];
                // The top bit of the derivative magnitude is set only for the negative
                // limit; below it the divider supplies one quotient bit a cycle, or the
                // saturated pattern is forced.
                d_ctrl.first = (cnt_reg == '0);
                d_ctrl.step  = 1'b1;
                if (cnt_reg == '0)
                begin
                    d_ctrl.digit = sat_reg & neg_reg;
                end
                else
                begin
                    d_ctrl.digit = sat_reg ? ~neg_reg : qbit;
                end
                div_ctrl.step = (cnt_reg < DIV_STEPS);
                pg_sh_next    = pg_sh_reg << 1;
                ig_sh_next    = ig_sh_reg << 1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == HORN_LAST)
                begin
                    state_next = S_FIN0;
                end
            end

            S_FIN0:
            begin
                // The integral product is floored back to Q.24.
                pi_next    = pac_pkg::PI_W'(p_prod)
                           + pac_pkg::PI_W'(i_prod >>> pac_pkg::FRAC_SHIFT);
                dsig_next  = neg_reg ? -d_prod : d_prod;
                state_next = S_FIN1;
            end

            S_FIN1:
            begin
                sum_next   = pac_pkg::SUM_W'(pi_reg) + pac_pkg::SUM_W'(dsig_reg);
                state_next = S_FIN2;
            end

            S_FIN2:
            begin
                if (out_load)
                begin
                    cutoff_next  = cutoff_calc;
                    clipped_next = 1'b0;
                    if (cutoff_calc)
                    begin
                        drive_next = '0;
                    end
                    else if (sum_reg > pac_pkg::OUT_MAX_Q24)
                    begin
                        drive_next   = pac_pkg::DRIVE_MAX;
                        clipped_next = 1'b1;
                    end
                    else if (sum_reg < pac_pkg::OUT_MIN_Q24)
                    begin
                        drive_next   = pac_pkg::DRIVE_MIN;
                        clipped_next = 1'b1;
                    end
                    else
                    begin
                        drive_next = $signed(sum_reg[pac_pkg::FRAC_SHIFT+pac_pkg::DRIVE_W-1:
                                                     pac_pkg::FRAC_SHIFT]);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register is loaded once per item and empties on its transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg   <= angle_next;
        period_reg  <= period_next;
        per_sh_reg  <= per_sh_next;
        err_reg     <= err_next;
        neg_reg     <= neg_next;
        sat_reg     <= sat_next;
        pg_sh_reg   <= pg_sh_next;
        ig_sh_reg   <= ig_sh_next;
        pi_reg      <= pi_next;
        dsig_reg    <= dsig_next;
        sum_reg     <= sum_next;
        drive_reg   <= drive_next;
        cutoff_reg  <= cutoff_next;
        clipped_reg <= clipped_next;
    end

    assign out_valid      = out_valid_reg;
    assign drive_value    = drive_reg;
    assign safety_cutoff  = cutoff_reg;
    assign output_clipped = clipped_reg;

endmodule
